FILE: hw/rtl/lcrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrt_pkg
// shared types, tables and mapping functions for the led channel remap table
// ----------------------------------------------------------------------------
package lcrt_pkg;

    localparam int unsigned MAP_DEPTH   = 192;
    localparam int unsigned INDEX_W     = $clog2(MAP_DEPTH);
    localparam logic [7:0]  MAX_CHANNEL = 8'd192;
    localparam logic [1:0]  COLOR_NONE  = 2'd3;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_RESTORE = 2'd2,
        KIND_RAW     = 2'd3
    } kind_t;

    // offsets within a row pair, indexed by hardware column and colour
    localparam logic [4:0] EVEN_OFFS [8][3] = '{
        '{5'd0,  5'd1,  5'd2 }, '{5'd3,  5'd4,  5'd5 },
        '{5'd6,  5'd7,  5'd8 }, '{5'd9,  5'd10, 5'd11},
        '{5'd12, 5'd13, 5'd14}, '{5'd15, 5'd23, 5'd22},
        '{5'd21, 5'd20, 5'd19}, '{5'd18, 5'd17, 5'd16}
    };

    localparam logic [4:0] ODD_OFFS [8][3] = '{
        '{5'd8,  5'd9,  5'd10}, '{5'd11, 5'd12, 5'd13},
        '{5'd14, 5'd15, 5'd16}, '{5'd17, 5'd18, 5'd19},
        '{5'd20, 5'd21, 5'd22}, '{5'd23, 5'd0,  5'd1 },
        '{5'd2,  5'd3,  5'd4 }, '{5'd5,  5'd6,  5'd7 }
    };

    // fixed hardware channel; hc must be 0 to 2
    function automatic logic [7:0] raw_lookup(input logic [2:0] x, input logic [2:0] y,
                                              input logic [1:0] hc);
        logic [2:0] my;
        logic [4:0] offs;
        logic [7:0] base;
        my   = 3'd7 - x;
        base = 8'd1 + 8'({6'd0, my[2:1]} * 8'd48) + (my[0] ? 8'd24 : 8'd0);
        offs = my[0] ? ODD_OFFS[y][hc] : EVEN_OFFS[y][hc];
        return base + {3'd0, offs};
    endfunction

    // default logical mapping of one entry; c must be 0 to 2
    function automatic logic [7:0] default_entry(input logic [2:0] x, input logic [2:0] y,
                                                 input logic [1:0] c);
        logic [7:0] ch;
        case (c)
            2'd0:    ch = raw_lookup(x, y, 2'd0);
            2'd1:    ch = raw_lookup(x, y - 3'd1, 2'd2);
            default: ch = raw_lookup(x, y, 2'd1);
        endcase
        if (x == 3'd0 && y == 3'd0 && c != 2'd2) begin
            ch = 8'd0;
        end
        return ch;
    endfunction

    function automatic logic [INDEX_W-1:0] entry_index(input logic [2:0] x,
                                                       input logic [2:0] y,
                                                       input logic [1:0] c);
        return INDEX_W'({5'd0, x} * 8'd24 + {5'd0, y} * 8'd3 + {6'd0, c});
    endfunction

endpackage

FILE: hw/rtl/led_channel_remap_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_channel_remap_table
// maps an 8x8 grid position and colour to an led driver channel
// ----------------------------------------------------------------------------
// the request and the ram read are registered, then the result moves to the output register
// once that register is free; no new input beat is taken while a request is held
// reset: map valid bits clear, so every entry reads its default mapping at once
// restore defaults clears all the valid bits at once, no sweep
module led_channel_remap_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // x[2:0], y[5:3], color[7:6], value[15:8]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // channel[7:0]
    output logic        m_axis_tuser    // ok
);

    localparam int unsigned IW = lcrt_pkg::INDEX_W;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg;

    // request held while the ram read completes
    lcrt_pkg::kind_t kind_reg;
    logic [2:0] x_reg;
    logic [2:0] y_reg;
    logic [1:0] color_reg;
    logic [7:0] value_reg;

    // map ram and the per-entry written flags
    logic [7:0]                   map_mem [lcrt_pkg::MAP_DEPTH];
    logic [lcrt_pkg::MAP_DEPTH-1:0] entry_valid_reg;
    logic [7:0]                   rd_data_reg;
    logic                         rd_hit_reg;

    // output register
    logic       m_valid_reg;
    logic [7:0] m_channel_reg;
    logic       m_ok_reg;

    logic            in_accept;
    lcrt_pkg::kind_t in_kind;
    logic [2:0]      in_x;
    logic [2:0]      in_y;
    logic [1:0]      in_color;
    logic [7:0]      in_value;
    logic            in_color_ok;
    logic [IW-1:0]   in_index;
    logic            mem_wr;
    logic            mem_rd;
    logic            restore;
    logic            out_free;
    logic            color_ok;
    logic [7:0]      res_channel;
    logic            res_ok;

    // unpack the beat
    assign in_kind     = lcrt_pkg::kind_t'(s_axis_tuser);
    assign in_x        = s_axis_tdata[2:0];
    assign in_y        = s_axis_tdata[5:3];
    assign in_color    = s_axis_tdata[7:6];
    assign in_value    = s_axis_tdata[15:8];
    assign in_color_ok = (in_color != lcrt_pkg::COLOR_NONE);
    assign in_index    = lcrt_pkg::entry_index(in_x, in_y, in_color);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // writes land at accept time, reads issue then and return registered in the next cycle
    assign mem_wr  = in_accept && (in_kind == lcrt_pkg::KIND_WRITE) && in_color_ok
                     && (in_value <= lcrt_pkg::MAX_CHANNEL);
    assign mem_rd  = in_accept && (in_kind == lcrt_pkg::KIND_READ) && in_color_ok;
    assign restore = in_accept && (in_kind == lcrt_pkg::KIND_RESTORE);

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            map_mem[in_index] <= in_value;
        end
        if (mem_rd) begin
            rd_data_reg <= map_mem[in_index];
            rd_hit_reg  <= entry_valid_reg[in_index];
        end
    end

    // an entry never written since reset or restore reads as its default
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (restore) begin
            entry_valid_reg <= '0;
        end else if (mem_wr) begin
            entry_valid_reg[in_index] <= 1'b1;
        end
    end

    // result of the held request
    assign color_ok = (color_reg != lcrt_pkg::COLOR_NONE);

    always_comb begin
        res_channel = 8'd0;
        res_ok      = 1'b0;
        case (kind_reg)
            lcrt_pkg::KIND_READ: begin
                if (color_ok) begin
                    res_channel = rd_hit_reg ? rd_data_reg
                                : lcrt_pkg::default_entry(x_reg, y_reg, color_reg);
                    res_ok      = 1'b1;
                end
            end
            lcrt_pkg::KIND_WRITE: begin
                if (color_ok && value_reg <= lcrt_pkg::MAX_CHANNEL) begin
                    res_channel = value_reg;
                    res_ok      = 1'b1;
                end
            end
            lcrt_pkg::KIND_RESTORE: begin
                res_ok = 1'b1;
            end
            default: begin
                if (color_ok) begin
                    res_channel = lcrt_pkg::raw_lookup(x_reg, y_reg, color_reg);
                    res_ok      = 1'b1;
                end
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    // request capture
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            kind_reg  <= in_kind;
            x_reg     <= in_x;
            y_reg     <= in_y;
            color_reg <= in_color;
            value_reg <= in_value;
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_axis_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (in_accept) begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    // hold the result here until the output register frees up
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_channel_reg <= res_channel;
                        m_ok_reg      <= res_ok;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_channel_reg;
    assign m_axis_tuser  = m_ok_reg;

endmodule

FILE: test/lcrt_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcrt_monitor
// watches both streams of the remap table, keeps a shadow copy of the map
// and checks every result beat against the predicted channel and ok flag
// ----------------------------------------------------------------------------
module lcrt_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // x[2:0], y[5:3], color[7:6], value[15:8]
    input  logic [1:0]  s_tuser,    // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // channel[7:0]
    input  logic        m_tuser,    // ok
    output int          mismatches,
    output int          outstanding
);

    localparam logic [1:0] SLOT_RED   = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_BLUE  = 2'd2;

    // hardware colour order on the driver: red, blue, green
    localparam logic [1:0] HW_RED   = 2'd0;
    localparam logic [1:0] HW_BLUE  = 2'd1;
    localparam logic [1:0] HW_GREEN = 2'd2;

    localparam logic [4:0] POS_EVEN [8][3] = '{
        '{5'd0,  5'd1,  5'd2 }, '{5'd3,  5'd4,  5'd5 },
        '{5'd6,  5'd7,  5'd8 }, '{5'd9,  5'd10, 5'd11},
        '{5'd12, 5'd13, 5'd14}, '{5'd15, 5'd23, 5'd22},
        '{5'd21, 5'd20, 5'd19}, '{5'd18, 5'd17, 5'd16}
    };

    localparam logic [4:0] POS_ODD [8][3] = '{
        '{5'd8,  5'd9,  5'd10}, '{5'd11, 5'd12, 5'd13},
        '{5'd14, 5'd15, 5'd16}, '{5'd17, 5'd18, 5'd19},
        '{5'd20, 5'd21, 5'd22}, '{5'd23, 5'd0,  5'd1 },
        '{5'd2,  5'd3,  5'd4 }, '{5'd5,  5'd6,  5'd7 }
    };

    typedef struct packed {
        logic [7:0] channel;
        logic       ok;
    } remap_result_t;

    logic [7:0]    shadow_map [lcrt_pkg::MAP_DEPTH];
    remap_result_t result_due [$];

    // driver channel wired to a grid position, 0 for the invalid colour
    function automatic logic [7:0] hw_channel(input logic [2:0] x, input logic [2:0] y,
                                              input logic [1:0] hc);
        int unsigned row;
        int unsigned ch;
        row = 7 - x;
        ch  = 1 + (row / 2) * 48 + (row % 2) * 24;
        if (hc == lcrt_pkg::COLOR_NONE) begin
            return 8'd0;
        end
        ch = ch + ((row % 2) ? POS_ODD[y][hc] : POS_EVEN[y][hc]);
        return 8'(ch);
    endfunction

    function automatic int unsigned map_slot(input logic [2:0] x, input logic [2:0] y,
                                             input logic [1:0] c);
        return (x * 8 + y) * 3 + c;
    endfunction

    task automatic load_factory_map();
        for (int x = 0; x < 8; x++) begin
            for (int y = 0; y < 8; y++) begin
                shadow_map[map_slot(3'(x), 3'(y), SLOT_RED)] =
                    hw_channel(3'(x), 3'(y), HW_RED);
                // green comes from the row above, wrapping round the grid
                shadow_map[map_slot(3'(x), 3'(y), SLOT_GREEN)] =
                    hw_channel(3'(x), 3'(y + 7), HW_GREEN);
                shadow_map[map_slot(3'(x), 3'(y), SLOT_BLUE)] =
                    hw_channel(3'(x), 3'(y), HW_BLUE);
            end
        end
        shadow_map[map_slot(3'd0, 3'd0, SLOT_RED)]   = 8'd0;
        shadow_map[map_slot(3'd0, 3'd0, SLOT_GREEN)] = 8'd0;
    endtask

    always @(posedge aclk) begin
        lcrt_pkg::kind_t kind;
        logic [2:0]      x;
        logic [2:0]      y;
        logic [1:0]      c;
        logic [7:0]      v;
        remap_result_t   want;
        remap_result_t   seen;
        if (!aresetn) begin
            load_factory_map();
            result_due.delete();
            mismatches = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                x    = s_tdata[2:0];
                y    = s_tdata[5:3];
                c    = s_tdata[7:6];
                v    = s_tdata[15:8];
                kind = lcrt_pkg::kind_t'(s_tuser);
                want = '{channel: 8'd0, ok: 1'b0};
                case (kind)
                    lcrt_pkg::KIND_READ: begin
                        if (c != lcrt_pkg::COLOR_NONE) begin
                            want = '{channel: shadow_map[map_slot(x, y, c)], ok: 1'b1};
                        end
                    end
                    lcrt_pkg::KIND_WRITE: begin
                        if (c != lcrt_pkg::COLOR_NONE && v <= lcrt_pkg::MAX_CHANNEL) begin
                            shadow_map[map_slot(x, y, c)] = v;
                            want = '{channel: v, ok: 1'b1};
                        end
                    end
                    lcrt_pkg::KIND_RESTORE: begin
                        load_factory_map();
                        want.ok = 1'b1;
                    end
                    default: begin
                        if (c != lcrt_pkg::COLOR_NONE) begin
                            want = '{channel: hw_channel(x, y, c), ok: 1'b1};
                        end
                    end
                endcase
                result_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                seen = '{channel: m_tdata, ok: m_tuser};
                if (result_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t lcrt_monitor: unexpected beat channel=%0d ok=%0b",
                                 $realtime, seen.channel, seen.ok);
                    end
                    mismatches++;
                end else begin
                    want = result_due.pop_front();
                    if (seen !== want) begin
                        if (mismatches < 10) begin
                            $display({"%0t lcrt_monitor: expected channel=%0d ok=%0b, ",
                                      "got channel=%0d ok=%0b"},
                                     $realtime, want.channel, want.ok,
                                     seen.channel, seen.ok);
                        end
                        mismatches++;
                    end
                end
            end
        end
        outstanding = result_due.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the led channel remap table: a directed pass over
// the corner cases, then a long random mix of reads, writes, restores and
// raw lookups with random idling on both streams and one long output stall
// ----------------------------------------------------------------------------
module tb_top;

    // store slot colours as seen on the input beat
    localparam logic [1:0] COL_RED   = 2'd0;
    localparam logic [1:0] COL_GREEN = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;

    localparam int RANDOM_BEATS = 1630;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;  // x[2:0], y[5:3], color[7:6], value[15:8]
    logic [1:0]  s_axis_tuser  = 2'd0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // channel[7:0]
    logic        m_axis_tuser;           // ok

    int fail_count;
    int pending;
    int beats_sent = 0;
    bit quiet      = 1'b0;   // no idling on either side while set
    bit stall_done = 1'b0;

    // last position written, reused so reads often hit fresh data
    logic [2:0] last_x = 3'd0;
    logic [2:0] last_y = 3'd0;
    logic [1:0] last_c = COL_RED;

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    led_channel_remap_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lcrt_monitor u_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    // called at a falling edge, returns at the falling edge after the beat is taken;
    // tvalid stays high between back-to-back beats
    task automatic send_beat(input lcrt_pkg::kind_t kind, input logic [2:0] x,
                             input logic [2:0] y, input logic [1:0] c,
                             input logic [7:0] v);
        // random idle cycles, with noise on the data bus while tvalid is low
        while (!quiet && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 16'($urandom);
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {v, c, y, x};
        s_axis_tuser  = kind;
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random_beat();
        int         pick;
        logic [2:0] x;
        logic [2:0] y;
        logic [1:0] c;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        x    = 3'($urandom_range(0, 7));
        y    = 3'($urandom_range(0, 7));
        c    = ($urandom_range(0, 99) < 8) ? lcrt_pkg::COLOR_NONE : 2'($urandom_range(0, 2));
        // mostly legal channels, some out of range, the edges now and then
        case ($urandom_range(0, 19))
            0:       v = 8'd0;
            1:       v = lcrt_pkg::MAX_CHANNEL;
            2, 3:    v = 8'($urandom_range(193, 255));
            default: v = 8'($urandom_range(0, 192));
        endcase
        // revisit the last written entry about a third of the time
        if (c != lcrt_pkg::COLOR_NONE && $urandom_range(0, 99) < 30) begin
            x = last_x;
            y = last_y;
            c = last_c;
        end
        if (pick < 3) begin
            send_beat(lcrt_pkg::KIND_RESTORE, x, y, c, v);
        end else if (pick < 38) begin
            if (c != lcrt_pkg::COLOR_NONE) begin
                last_x = x;
                last_y = y;
                last_c = c;
            end
            send_beat(lcrt_pkg::KIND_WRITE, x, y, c, v);
        end else if (pick < 72) begin
            send_beat(lcrt_pkg::KIND_READ, x, y, c, v);
        end else begin
            send_beat(lcrt_pkg::KIND_RAW, x, y, c, v);
        end
    endtask

    // result side: random back-pressure, one long hold-off early in the run
    initial begin
        forever begin
            @(negedge aclk);
            if (!stall_done && beats_sent >= 250) begin
                stall_done    = 1'b1;
                m_axis_tready = 1'b0;
                repeat (300) @(negedge aclk);
            end
            m_axis_tready = quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // raw lookups: grid corners, odd hardware row, invalid colour
        send_beat(lcrt_pkg::KIND_RAW, 3'd0, 3'd0, COL_RED, 8'd0);
        send_beat(lcrt_pkg::KIND_RAW, 3'd7, 3'd7, COL_BLUE, 8'd255);
        send_beat(lcrt_pkg::KIND_RAW, 3'd0, 3'd5, COL_GREEN, 8'd0);
        send_beat(lcrt_pkg::KIND_RAW, 3'd7, 3'd0, COL_GREEN, 8'd0);
        send_beat(lcrt_pkg::KIND_RAW, 3'd3, 3'd4, lcrt_pkg::COLOR_NONE, 8'd0);

        // default map: blanked corner, far corner, green wrapping from the top row
        send_beat(lcrt_pkg::KIND_READ, 3'd0, 3'd0, COL_RED, 8'd0);
        send_beat(lcrt_pkg::KIND_READ, 3'd0, 3'd0, COL_GREEN, 8'd0);
        send_beat(lcrt_pkg::KIND_READ, 3'd0, 3'd0, COL_BLUE, 8'd0);
        send_beat(lcrt_pkg::KIND_READ, 3'd7, 3'd7, COL_BLUE, 8'd0);
        send_beat(lcrt_pkg::KIND_READ, 3'd5, 3'd0, COL_GREEN, 8'd0);
        send_beat(lcrt_pkg::KIND_READ, 3'd2, 3'd3, lcrt_pkg::COLOR_NONE, 8'd0);

        // writes at and beyond the top channel, zero, invalid colour
        send_beat(lcrt_pkg::KIND_WRITE, 3'd4, 3'd4, COL_RED, lcrt_pkg::MAX_CHANNEL);
        send_beat(lcrt_pkg::KIND_READ, 3'd4, 3'd4, COL_RED, 8'd0);
        send_beat(lcrt_pkg::KIND_WRITE, 3'd4, 3'd4, COL_GREEN, 8'd193);
        send_beat(lcrt_pkg::KIND_READ, 3'd4, 3'd4, COL_GREEN, 8'd0);
        send_beat(lcrt_pkg::KIND_WRITE, 3'd6, 3'd1, COL_BLUE, 8'd255);
        send_beat(lcrt_pkg::KIND_WRITE, 3'd6, 3'd1, COL_BLUE, 8'd0);
        send_beat(lcrt_pkg::KIND_WRITE, 3'd1, 3'd2, lcrt_pkg::COLOR_NONE, 8'd10);

        // restore ignores the other fields, then the written entries read defaults
        send_beat(lcrt_pkg::KIND_RESTORE, 3'd7, 3'd7, lcrt_pkg::COLOR_NONE, 8'd255);
        send_beat(lcrt_pkg::KIND_READ, 3'd4, 3'd4, COL_RED, 8'd0);
        send_beat(lcrt_pkg::KIND_READ, 3'd6, 3'd1, COL_BLUE, 8'd0);

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            // a stretch of back-to-back traffic with no idling
            quiet = (i >= 400 && i < 700);
            send_random_beat();
        end
        s_axis_tvalid = 1'b0;

        while (pending != 0) @(posedge aclk);
        // allow for any late or spurious beat
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
